// ===== hw/rtl/v3alu_pkg.sv =====
// Shared types, opcodes, status codes and helper functions for the vector ALU.
package v3alu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SUMSQ_W = 66;
  localparam int unsigned ROOT_W = 33;
  localparam int unsigned ROOT_STEPS = 33;
  localparam int unsigned QUO_W = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DOT = 3'd2,
    OP_CROSS = 3'd3,
    OP_SCALE = 3'd4,
    OP_DIV = 3'd5,
    OP_MAG = 3'd6,
    OP_UNIT = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_NULL = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  // Saturate a wide signed value to the 32-bit range.
  function automatic logic [32:0] sat_wide(input logic signed [99:0] v);
    logic [32:0] r;
    if (v > 100'sh7FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
    else if (v < -100'sh80000000) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // Apply a sign to an unsigned magnitude and saturate.
  function automatic logic [32:0] sat_mag(input logic neg, input logic [QUO_W-1:0] m);
    logic [32:0] r;
    if (neg) begin
      if (m > 64'h80000000) r = {1'b1, 32'h80000000};
      else r = {1'b0, 32'(-m[31:0])};
    end else begin
      if (m > 64'h7FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/v3alu_lane.sv =====
// One component lane: registered products, sum and difference.
module v3alu_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] p,
  input  logic signed [31:0] q,
  input  logic signed [31:0] s,
  output logic signed [63:0] prod_ab,
  output logic signed [63:0] prod_pq,
  output logic signed [63:0] prod_as,
  output logic signed [32:0] sum_ab,
  output logic signed [32:0] dif_ab
);
  // Stage one multiply products; register before any use.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_ab <= 64'(a) * 64'(b);
      prod_pq <= 64'(p) * 64'(q);
      prod_as <= 64'(a) * 64'(s);
      sum_ab  <= 33'(a) + 33'(b);
      dif_ab  <= 33'(a) - 33'(b);
    end
  end
endmodule

// ===== hw/rtl/v3alu_divider.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3alu_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [NUM_W-1:0] n_r [NUM_W+1];
  logic [DEN_W:0]   r_r [NUM_W+1];
  logic [NUM_W-1:0] q_r [NUM_W+1];
  logic [DEN_W-1:0] d_r [NUM_W+1];

  assign n_r[0] = num;
  assign r_r[0] = '0;
  assign q_r[0] = '0;
  assign d_r[0] = den;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] shifted;
    assign shifted = {r_r[k], n_r[k][NUM_W-1]};
    assign trial = shifted - {1'b0, 1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= {n_r[k][NUM_W-2:0], 1'b0};
        d_r[k+1] <= d_r[k];
        if (!trial[DEN_W+1]) begin
          r_r[k+1] <= trial[DEN_W:0];
          q_r[k+1] <= {q_r[k][NUM_W-2:0], 1'b1};
        end else begin
          r_r[k+1] <= shifted[DEN_W:0];
          q_r[k+1] <= {q_r[k][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[NUM_W];
endmodule

// ===== hw/rtl/v3alu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module v3alu_sqrt (
  input  logic         clk,
  input  logic         en,
  input  logic [65:0]  x,
  output logic [32:0]  root
);
  localparam int STEPS = v3alu_pkg::ROOT_STEPS;
  logic [65:0] rem_r [STEPS+1];
  logic [65:0] x_r   [STEPS+1];
  logic [32:0] r_r   [STEPS+1];

  assign rem_r[0] = '0;
  assign x_r[0]   = x;
  assign r_r[0]   = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [67:0] sh;
    logic [67:0] trial;
    assign sh = {rem_r[k], x_r[k][65:64]};
    assign trial = sh - {33'd0, r_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1] <= {x_r[k][63:0], 2'b00};
        if (!trial[67]) begin
          rem_r[k+1] <= trial[65:0];
          r_r[k+1] <= {r_r[k][31:0], 1'b1};
        end else begin
          rem_r[k+1] <= sh[65:0];
          r_r[k+1] <= {r_r[k][31:0], 1'b0};
        end
      end
    end
  end

  // Remainder x - r*r exceeds r: round up.
  assign root = r_r[STEPS] + 33'(rem_r[STEPS] > 66'(r_r[STEPS]));
endmodule

// ===== hw/rtl/vector3_alu_unit.sv =====
// Vector ALU top: three lanes, shared root, dividers and merging stage.
// Usage:
//   s_axis carries one item per transfer: opcode in tuser, the two vectors
//   and scalar in tdata. m_axis returns one result per item: res vector and
//   res_scalar in tdata, a_is_null and status in tuser. cfg_* writes the
//   null threshold (31 bits); write it only while the block is empty.
//   Pipeline stages, in order: the product stage, the merge stage, 33
//   square-root stages, one divide prep stage, 64 divider stages and the
//   output register. The pipeline takes one item each cycle when the
//   output is taken or the output register is empty.
//   The whole pipeline advances together; when m_axis_tready is low and
//   the output register is full, the pipeline holds and s_axis_tready
//   drops. Reset clears valid bits and the threshold to zero; payload
//   registers are not reset. Throughput is one item per cycle unless m_axis
//   stalls, set by the fully pipelined square root and divider stages.
module vector3_alu_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [223:0] s_axis_tdata,
  // opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_x, res_y, res_z, res_scalar
  output logic [127:0] m_axis_tdata,
  // a_is_null, status
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);
  localparam int DIV_LAT = 64;
  localparam int SQ_LAT = v3alu_pkg::ROOT_STEPS;
  // stage 1 products, stage 2 sums, sqrt SQ_LAT, quotient prep, divider, output.
  localparam int LAT = 2 + SQ_LAT + 1 + DIV_LAT + 1;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  logic [30:0] null_threshold;
  logic en;
  logic [LAT-1:0] vld;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) null_threshold <= '0;
    else if (cfg_valid) null_threshold <= cfg_data;
  end

  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] sc;
  for (genvar i = 0; i < 3; i++) begin : g_unp
    assign av[i] = s_axis_tdata[32*i +: 32];
    assign bv[i] = s_axis_tdata[96 + 32*i +: 32];
  end
  assign sc = s_axis_tdata[192 +: 32];

  // Lanes: prod_ab is a_i*b_i, prod_pq a cross term, prod_as a_i*s.
  logic signed [63:0] pab [3];
  logic signed [63:0] ppq [3];
  logic signed [63:0] pas [3];
  logic signed [32:0] sab [3];
  logic signed [32:0] dab [3];
  logic signed [63:0] cr1 [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3alu_lane u_lane (
      .clk, .en, .a(av[i]), .b(bv[i]), .p(bv[J]), .q(av[K]), .s(sc),
      .prod_ab(pab[i]), .prod_pq(ppq[i]), .prod_as(pas[i]),
      .sum_ab(sab[i]), .dif_ab(dab[i])
    );
    always_ff @(posedge clk) begin
      if (en) cr1[i] <= 64'(av[J]) * 64'(bv[K]);
    end
  end

  // Stage 1 side registers.
  logic [2:0] op1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] s1;
  logic [63:0] sq1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_axis_tuser;
      s1 <= sc;
      for (int i = 0; i < 3; i++) begin
        a1[i] <= av[i];
        sq1[i] <= 64'(av[i]) * 64'(av[i]);
      end
    end
  end

  // Stage 2: merge sums and round; add, sub, dot, cross and scale results, and the sum of squares.
  logic [2:0] op2;
  logic signed [31:0] a2 [3];
  logic signed [31:0] s2;
  logic [65:0] sumsq2;
  logic [31:0] rv2 [3];
  logic [31:0] rs2;
  logic sat2;
  always_ff @(posedge clk) begin
    logic signed [99:0] acc;
    logic [32:0] t;
    logic sat;
    logic [31:0] rv_next [3];
    logic [31:0] rs_next;
    if (en) begin
      op2 <= op1;
      a2 <= a1;
      s2 <= s1;
      sumsq2 <= 66'(sq1[0]) + 66'(sq1[1]) + 66'(sq1[2]);
      sat = 1'b0;
      rs_next = '0;
      for (int i = 0; i < 3; i++) rv_next[i] = '0;
      case (v3alu_pkg::opcode_t'(op1))
        v3alu_pkg::OP_ADD: begin
          for (int i = 0; i < 3; i++) begin
            t = v3alu_pkg::sat_wide(100'(sab[i]));
            rv_next[i] = t[31:0];
            sat = sat | t[32];
          end
        end
        v3alu_pkg::OP_SUB: begin
          for (int i = 0; i < 3; i++) begin
            t = v3alu_pkg::sat_wide(100'(dab[i]));
            rv_next[i] = t[31:0];
            sat = sat | t[32];
          end
        end
        v3alu_pkg::OP_DOT: begin
          acc = 100'(pab[0]) + 100'(pab[1]) + 100'(pab[2]) + 100'(HALF);
          t = v3alu_pkg::sat_wide(acc >>> FRAC_BITS);
          rs_next = t[31:0];
          sat = t[32];
        end
        v3alu_pkg::OP_CROSS: begin
          for (int i = 0; i < 3; i++) begin
            acc = 100'(cr1[i]) - 100'(ppq[i]) + 100'(HALF);
            t = v3alu_pkg::sat_wide(acc >>> FRAC_BITS);
            rv_next[i] = t[31:0];
            sat = sat | t[32];
          end
        end
        v3alu_pkg::OP_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            acc = 100'(pas[i]) + 100'(HALF);
            t = v3alu_pkg::sat_wide(acc >>> FRAC_BITS);
            rv_next[i] = t[31:0];
            sat = sat | t[32];
          end
        end
        default: ;
      endcase
      rv2 <= rv_next;
      rs2 <= rs_next;
      sat2 <= sat;
    end
  end

  logic [32:0] mag;
  v3alu_sqrt u_sqrt (.clk, .en, .x(sumsq2), .root(mag));

  // Delay line alongside the root.
  logic [2:0] opd [SQ_LAT+1];
  logic signed [31:0] ad [SQ_LAT+1][3];
  logic signed [31:0] sd [SQ_LAT+1];
  logic [31:0] rvd [SQ_LAT+1][3];
  logic [31:0] rsd [SQ_LAT+1];
  logic satd [SQ_LAT+1];
  assign opd[0] = op2;
  assign ad[0] = a2;
  assign sd[0] = s2;
  assign rvd[0] = rv2;
  assign rsd[0] = rs2;
  assign satd[0] = sat2;
  for (genvar k = 0; k < SQ_LAT; k++) begin : g_sqd
    always_ff @(posedge clk) begin
      if (en) begin
        opd[k+1] <= opd[k];
        ad[k+1] <= ad[k];
        sd[k+1] <= sd[k];
        rvd[k+1] <= rvd[k];
        rsd[k+1] <= rsd[k];
        satd[k+1] <= satd[k];
      end
    end
  end

  // Divide prep stage; also finishes the magnitude and sets null and divide-by-zero status.
  logic [2:0] op3;
  logic null3;
  logic [31:0] rv3 [3];
  logic [31:0] rs3;
  logic sat3;
  logic [1:0] st3;
  logic [63:0] num3 [3];
  logic [32:0] den3;
  logic [2:0] neg3;
  logic divop3;
  always_ff @(posedge clk) begin
    logic [32:0] d;
    logic [32:0] t;
    logic isnull;
    logic dn;
    logic [31:0] rs_next;
    logic sat_next;
    logic [1:0] st_next;
    logic div_next;
    if (en) begin
      isnull = mag <= 33'(null_threshold);
      rs_next = rsd[SQ_LAT];
      sat_next = satd[SQ_LAT];
      st_next = v3alu_pkg::ST_OK;
      div_next = 1'b0;
      dn = 1'b0;
      d = mag;
      if (opd[SQ_LAT] == v3alu_pkg::OP_MAG) begin
        t = v3alu_pkg::sat_mag(1'b0, 64'(mag));
        rs_next = t[31:0];
        sat_next = t[32];
      end else if (opd[SQ_LAT] == v3alu_pkg::OP_DIV) begin
        dn = sd[SQ_LAT][31];
        d = dn ? 33'(-33'(sd[SQ_LAT])) : 33'(sd[SQ_LAT]);
        if (sd[SQ_LAT] == '0) st_next = v3alu_pkg::ST_DIV_ZERO;
        else div_next = 1'b1;
      end else if (opd[SQ_LAT] == v3alu_pkg::OP_UNIT) begin
        if (isnull) st_next = v3alu_pkg::ST_NULL;
        else div_next = 1'b1;
      end
      op3 <= opd[SQ_LAT];
      null3 <= isnull;
      rv3 <= rvd[SQ_LAT];
      rs3 <= rs_next;
      sat3 <= sat_next;
      st3 <= st_next;
      divop3 <= div_next;
      den3 <= d;
      for (int i = 0; i < 3; i++) begin
        logic [32:0] m;
        m = ad[SQ_LAT][i][31] ? 33'(-33'(ad[SQ_LAT][i])) : 33'(ad[SQ_LAT][i]);
        // n*2^F + d/2 as dividend.
        num3[i] <= (64'(m) << FRAC_BITS) + 64'(d >> 1);
        neg3[i] <= ad[SQ_LAT][i][31] ^ dn;
      end
    end
  end

  logic [63:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_divider #(.NUM_W(64), .DEN_W(33)) u_div (
      .clk, .en, .num(num3[i]), .den(den3), .quo(quo[i])
    );
  end

  logic null_d [DIV_LAT+1];
  logic [31:0] rvq [DIV_LAT+1][3];
  logic [31:0] rsq [DIV_LAT+1];
  logic satq [DIV_LAT+1];
  logic [1:0] stq [DIV_LAT+1];
  logic [2:0] negq [DIV_LAT+1];
  logic divq [DIV_LAT+1];
  assign null_d[0] = null3;
  assign rvq[0] = rv3;
  assign rsq[0] = rs3;
  assign satq[0] = sat3;
  assign stq[0] = st3;
  assign negq[0] = neg3;
  assign divq[0] = divop3;
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_dvd
    always_ff @(posedge clk) begin
      if (en) begin
        null_d[k+1] <= null_d[k];
        rvq[k+1] <= rvq[k];
        rsq[k+1] <= rsq[k];
        satq[k+1] <= satq[k];
        stq[k+1] <= stq[k];
        negq[k+1] <= negq[k];
        divq[k+1] <= divq[k];
      end
    end
  end

  // Output register: merge the lanes.
  logic [31:0] ox [3];
  logic [31:0] osc;
  logic onull;
  logic [1:0] ost;
  always_ff @(posedge clk) begin
    logic [32:0] t;
    logic sat;
    if (en) begin
      sat = satq[DIV_LAT];
      for (int i = 0; i < 3; i++) begin
        if (divq[DIV_LAT]) begin
          t = v3alu_pkg::sat_mag(negq[DIV_LAT][i] && quo[i] != '0, quo[i]);
          ox[i] <= t[31:0];
          sat = sat | t[32];
        end else begin
          ox[i] <= rvq[DIV_LAT][i];
        end
      end
      osc <= rsq[DIV_LAT];
      onull <= null_d[DIV_LAT];
      if (stq[DIV_LAT] == v3alu_pkg::ST_OK && sat) ost <= v3alu_pkg::ST_SAT;
      else ost <= stq[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end

  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata = {osc, ox[2], ox[1], ox[0]};
  assign m_axis_tuser = {ost, onull};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output");
  a_null: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:1] == v3alu_pkg::ST_NULL |-> m_axis_tuser[0])
    else $error("null status without null flag");
endmodule
